// ===== hdl/dmpb_pkg.sv =====
// ----------------------------------------------------------------------------
// dmpb_pkg
// shared constants, types and pixel helpers of the deinterlace post filter
// ----------------------------------------------------------------------------
package dmpb_pkg;

    localparam int MAX_WIDTH    = 2048;
    localparam int PIXEL_BITS   = 8;
    localparam int COL_BITS     = 11;
    localparam int ROW_BITS     = 12;
    localparam int WIDTH_BITS   = 12;
    localparam int HEIGHT_BITS  = 13;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DAT_BITS = 13;
    localparam int LB_DEPTH     = MAX_WIDTH;
    localparam int LB_ADDR_BITS = $clog2(LB_DEPTH);

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FIELD_PARITY = 2'd2;

    localparam logic [WIDTH_BITS-1:0]  RST_FRAME_WIDTH  = 12'd720;
    localparam logic [HEIGHT_BITS-1:0] RST_FRAME_HEIGHT = 13'd576;

    typedef logic [PIXEL_BITS-1:0] pix_t;

    // line buffer access of one cycle
    typedef struct packed {
        logic                    rd_en;
        logic [LB_ADDR_BITS-1:0] rd_addr;
        logic                    wr_en;
        logic [LB_ADDR_BITS-1:0] wr_addr;
        pix_t                    wr_data;
    } lbuf_req_t;

    function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
        pix_t m;
        begin
            if ((a <= b && b <= c) || (a >= b && b >= c))
                m = b;
            else if ((a <= c && c <= b) || (a >= c && c >= b))
                m = c;
            else
                m = a;
            return m;
        end
    endfunction

    // median of neighbors and (edge + 3*motion)/4
    function automatic pix_t protect(input pix_t above, input pix_t motion,
                                     input pix_t edge_s, input pix_t below);
        logic [PIXEL_BITS+1:0] sum;
        begin
            sum = {2'b00, edge_s} + {2'b00, motion} + {1'b0, motion, 1'b0};
            return med3(above, sum[PIXEL_BITS+1:2], below);
        end
    endfunction

endpackage

// ===== hdl/dmpb_lbuf.sv =====
// ----------------------------------------------------------------------------
// dmpb_lbuf
// previous output row store, one read and one write a cycle, with bypass
// ----------------------------------------------------------------------------
module dmpb_lbuf
    import dmpb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  lbuf_req_t req,
    output pix_t      rd_data
);

    pix_t mem [LB_DEPTH];
    pix_t q_reg;
    logic fwd_valid_reg;
    pix_t fwd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
            mem[req.wr_addr] <= req.wr_data;
        if (req.rd_en)
        begin
            q_reg        <= mem[req.rd_addr];
            fwd_data_reg <= req.wr_data;
        end
    end

    // a write in the same cycle as a read of that entry wins
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fwd_valid_reg <= 1'b0;
        else if (req.rd_en)
            fwd_valid_reg <= req.wr_en && (req.wr_addr == req.rd_addr);
    end

    assign rd_data = fwd_valid_reg ? fwd_data_reg : q_reg;

endmodule

// ===== hdl/deinterlace_median_protect_blend.sv =====
// ----------------------------------------------------------------------------
// deinterlace_median_protect_blend
// deinterlacer post filter: median protection and recursive vertical blend
// ----------------------------------------------------------------------------
// One pixel per clock while the output is not stalled. A beat accepted on the
// input is protected in the accept cycle while its column's previous-row entry
// is read from the single-port-read line buffer. Once the output register is
// free, the blend stage blends it, writes the entry back and loads the output
// register. The read-modify-write of the line buffer sets the rate: one
// read and one write per cycle, with a bypass when the write and a new read
// hit the same column. Beats outside the frame are accepted and dropped.
// The line buffer has no reset; the user must see that a row is only blended
// against entries that the row above wrote; the block does not enforce it.
module deinterlace_median_protect_blend
    import dmpb_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_DAT_BITS-1:0] cfg_data,

    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [COL_BITS-1:0]     column,
    input  logic [ROW_BITS-1:0]     row,
    input  pix_t                    mc_above,
    input  pix_t                    mc_here,
    input  pix_t                    mc_below,
    input  pix_t                    mc_below_two,
    input  pix_t                    edge_here,
    input  pix_t                    edge_below,

    output logic                    out_valid,
    input  logic                    out_ready,
    output pix_t                    pixel_out,
    output logic [COL_BITS-1:0]     out_column
);

    // configuration
    logic [WIDTH_BITS-1:0]  width_reg;
    logic [HEIGHT_BITS-1:0] height_reg;
    logic                   parity_reg;

    // blend stage
    logic                s1_valid_reg;
    logic [COL_BITS-1:0] s1_col_reg;
    pix_t                s1_here_reg;
    pix_t                s1_below_reg;
    logic                s1_blend_reg;

    // output register
    logic                out_valid_reg;
    pix_t                out_pix_reg;
    logic [COL_BITS-1:0] out_col_reg;

    // protect stage, combinational on the input beat
    logic [HEIGHT_BITS-1:0] row_p1;
    logic [HEIGHT_BITS:0]   row_p2;
    logic                   has_below;
    logic                   has_below2;
    logic                   interp_here;
    logic                   interp_below;
    logic                   in_frame;
    logic                   in_take;
    pix_t                   here_next;
    pix_t                   below_next;
    logic                   blend_next;

    // blend
    logic                  s1_adv;
    pix_t                  prev_pix;
    logic [PIXEL_BITS+1:0] blend_sum;
    pix_t                  pix_next;
    lbuf_req_t             lb_req;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_FRAME_WIDTH;
            height_reg <= RST_FRAME_HEIGHT;
            parity_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_FRAME_WIDTH:  width_reg  <= cfg_data[WIDTH_BITS-1:0];
                CFG_FRAME_HEIGHT: height_reg <= cfg_data[HEIGHT_BITS-1:0];
                CFG_FIELD_PARITY: parity_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // row geometry
    assign row_p1       = {1'b0, row} + 1'b1;
    assign row_p2       = {2'b00, row} + 2'd2;
    assign has_below    = row_p1 < height_reg;
    assign has_below2   = row_p2 < {1'b0, height_reg};
    assign interp_here  = (row != '0) && (row[0] != parity_reg);
    // the row below has the other parity
    assign interp_below = (row[0] == parity_reg);
    assign blend_next   = (row != '0) && has_below;
    assign in_frame     = ({1'b0, column} < width_reg) && ({1'b0, row} < height_reg);

    always_comb
    begin
        if (interp_here)
            // missing row below: row above stands in
            here_next = protect(mc_above, mc_here, edge_here,
                                has_below ? mc_below : mc_above);
        else
            here_next = mc_here;
        if (interp_below)
            below_next = protect(mc_here, mc_below, edge_below,
                                 has_below2 ? mc_below_two : mc_here);
        else
            below_next = mc_below;
    end

    // handshake: blend stage moves when the output register frees up
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign in_take  = in_valid && in_ready && in_frame;

    // recursive [1 2 1]/4 against the previous output row
    assign blend_sum = {2'b00, prev_pix} + {1'b0, s1_here_reg, 1'b0}
                     + {2'b00, s1_below_reg};
    assign pix_next  = s1_blend_reg ? blend_sum[PIXEL_BITS+1:2] : s1_here_reg;

    always_comb
    begin
        lb_req.rd_en   = in_take;
        lb_req.rd_addr = column[LB_ADDR_BITS-1:0];
        lb_req.wr_en   = s1_adv;
        lb_req.wr_addr = s1_col_reg[LB_ADDR_BITS-1:0];
        lb_req.wr_data = pix_next;
    end

    dmpb_lbuf u_lbuf
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (lb_req),
        .rd_data (prev_pix)
    );

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_take;
            if (s1_adv)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_col_reg   <= column;
            s1_here_reg  <= here_next;
            s1_below_reg <= below_next;
            s1_blend_reg <= blend_next;
        end
        if (s1_adv)
        begin
            out_pix_reg <= pix_next;
            out_col_reg <= s1_col_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pixel_out  = out_pix_reg;
    assign out_column = out_col_reg;

`ifndef SYNTHESIS
    // a stalled blend stage keeps its beat
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> s1_valid_reg && $stable(s1_col_reg))
        else $error("blend stage lost its beat while stalled");

    // beats outside the frame never reach the blend stage
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !in_frame |=> !s1_valid_reg)
        else $error("out-of-frame beat entered the pipeline");

    // a new result comes only from the blend stage
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg))
        else $error("result without a beat in the blend stage");

    // the line buffer is written exactly when a result is produced
    assert property (@(posedge clk) disable iff (!rst_n)
        lb_req.wr_en |=> out_valid_reg && out_col_reg == $past(s1_col_reg))
        else $error("line buffer write without matching result");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the deinterlace median protect and blend filter
// ----------------------------------------------------------------------------
// Pixel beats go in through a bursty sender. The bench predicts each beat's
// filtered pixel against its own model of the line buffer and the frame
// registers. A checker compares every output beat, in order, with the oldest
// predicted pixel. Directed beats cover the field extremes and the frame edge
// cases. Random raster frames and scattered positions with out-of-frame noise
// come after that. The output side stalls in modes that change over time.
// ----------------------------------------------------------------------------
module tb_top;
    import dmpb_pkg::*;

    localparam int unsigned TIMEOUT_CYCLES = 400000;
    localparam int unsigned SETTLE_CYCLES  = 4;  // two-stage pipe plus margin
    localparam int unsigned MAX_ROW        = 4095;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;  // no register here

    typedef struct {
        logic [COL_BITS-1:0] column;
        logic [ROW_BITS-1:0] row;
        pix_t                mc_above;
        pix_t                mc_here;
        pix_t                mc_below;
        pix_t                mc_below_two;
        pix_t                edge_here;
        pix_t                edge_below;
    } pixel_beat_t;

    typedef struct {
        pix_t                pixel;
        logic [COL_BITS-1:0] col;
    } blended_pixel_t;

    typedef enum logic [1:0] {RDY_ALWAYS, RDY_MOSTLY, RDY_SPARSE, RDY_PERIODIC} ready_mode_t;

    // dut ports, the driven ones known from time zero
    logic                    clk          = 1'b0;
    logic                    rst_n        = 1'b0;
    logic                    cfg_valid    = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index    = '0;
    logic [CFG_DAT_BITS-1:0] cfg_data     = '0;
    logic                    in_valid     = 1'b0;
    logic                    in_ready;
    logic [COL_BITS-1:0]     column       = '0;
    logic [ROW_BITS-1:0]     row          = '0;
    pix_t                    mc_above     = '0;
    pix_t                    mc_here      = '0;
    pix_t                    mc_below     = '0;
    pix_t                    mc_below_two = '0;
    pix_t                    edge_here    = '0;
    pix_t                    edge_below   = '0;
    logic                    out_valid;
    logic                    out_ready    = 1'b0;
    pix_t                    pixel_out;
    logic [COL_BITS-1:0]     out_column;

    // bench-side copy of the frame registers and the previous output row
    logic [WIDTH_BITS-1:0]   cur_width  = RST_FRAME_WIDTH;
    logic [HEIGHT_BITS-1:0]  cur_height = RST_FRAME_HEIGHT;
    logic                    cur_parity = 1'b0;
    pix_t                    blended_line [MAX_WIDTH];
    bit                      line_written [MAX_WIDTH];
    blended_pixel_t          expected_pixels [$];

    int unsigned             mismatches  = 0;
    int unsigned             cycle_count = 0;
    int unsigned             burst_left  = 1;
    ready_mode_t             ready_mode  = RDY_ALWAYS;
    int unsigned             mode_left   = 0;

    deinterlace_median_protect_blend DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .column       (column),
        .row          (row),
        .mc_above     (mc_above),
        .mc_here      (mc_here),
        .mc_below     (mc_below),
        .mc_below_two (mc_below_two),
        .edge_here    (edge_here),
        .edge_below   (edge_below),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_out    (pixel_out),
        .out_column   (out_column)
    );

    always #5 clk = ~clk;

    // run limit, far above the slowest legal run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > TIMEOUT_CYCLES)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    // rows of the missing field get the median protection
    function automatic bit interp_row(input int unsigned r);
        return r >= 1 && (r & 1) != cur_parity;
    endfunction

    // median of above, below and the edge/motion mix is the mix clamped
    // between the two neighbors
    function automatic int unsigned guard_interp(input int unsigned above,
                                                 input int unsigned motion,
                                                 input int unsigned edge_px,
                                                 input int unsigned below);
        int unsigned mix;
        int unsigned lo;
        int unsigned hi;
        mix = (edge_px + 3 * motion) / 4;
        lo  = (above < below) ? above : below;
        hi  = (above < below) ? below : above;
        return (mix < lo) ? lo : ((mix > hi) ? hi : mix);
    endfunction

    task automatic predict_filtered_pixel(input pixel_beat_t b);
        int unsigned    r;
        int unsigned    h;
        int unsigned    here;
        int unsigned    below;
        int unsigned    pix;
        blended_pixel_t res;
        r = b.row;
        h = cur_height;
        // beats outside the frame leave no trace
        if (b.column >= cur_width || r >= h)
            return;
        // missing row below: the row above stands in
        if (interp_row(r))
            here = guard_interp(b.mc_above, b.mc_here, b.edge_here,
                                (r + 1 < h) ? b.mc_below : b.mc_above);
        else
            here = b.mc_here;
        // first and last rows pass through, the rest blend [1 2 1]/4
        if (r >= 1 && r + 1 < h)
        begin
            if (interp_row(r + 1))
                below = guard_interp(b.mc_here, b.mc_below, b.edge_below,
                                     (r + 2 < h) ? b.mc_below_two : b.mc_here);
            else
                below = b.mc_below;
            pix = (blended_line[b.column] + 2 * here + below) / 4;
        end
        else
        begin
            pix = here;
        end
        blended_line[b.column] = pix[PIXEL_BITS-1:0];
        line_written[b.column] = 1'b1;
        res.pixel = pix[PIXEL_BITS-1:0];
        res.col   = b.column;
        expected_pixels.push_back(res);
    endtask

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 40)
            $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    always @(posedge clk)
    begin : check_results
        blended_pixel_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                report_mismatch($sformatf("unexpected beat pixel %0d column %0d",
                                          pixel_out, out_column));
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (pixel_out !== want.pixel)
                    report_mismatch($sformatf("pixel_out %0d, want %0d (column %0d)",
                                              pixel_out, want.pixel, want.col));
                if (out_column !== want.col)
                    report_mismatch($sformatf("out_column %0d, want %0d",
                                              out_column, want.col));
            end
        end
    end

    // ------------------------------------------------------------------------
    // output stalls: a mode holds for a while, then another takes over
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            ready_mode <= ready_mode_t'($urandom_range(0, 3));
            mode_left  <= $urandom_range(16, 160);
        end
        else
        begin
            mode_left <= mode_left - 1;
        end
        case (ready_mode)
            RDY_ALWAYS:   out_ready <= 1'b1;
            RDY_MOSTLY:   out_ready <= ($urandom_range(0, 3) != 0);
            RDY_SPARSE:   out_ready <= ($urandom_range(0, 3) == 0);
            RDY_PERIODIC: out_ready <= (cycle_count % 6 == 0);
            default:      out_ready <= 1'b1;
        endcase
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    function automatic pixel_beat_t fixed_beat(input int unsigned c, input int unsigned r,
                                               input pix_t ma, input pix_t mh,
                                               input pix_t mb, input pix_t mb2,
                                               input pix_t eh, input pix_t eb);
        pixel_beat_t b;
        b.column       = c[COL_BITS-1:0];
        b.row          = r[ROW_BITS-1:0];
        b.mc_above     = ma;
        b.mc_here      = mh;
        b.mc_below     = mb;
        b.mc_below_two = mb2;
        b.edge_here    = eh;
        b.edge_below   = eb;
        return b;
    endfunction

    // samples either scattered or clustered around one level, so that all
    // three median picks and the blend see both wide and close values
    function automatic pixel_beat_t make_beat(input int unsigned c, input int unsigned r);
        int unsigned base;
        bit          wild;
        int          s;
        pix_t        v [6];
        base = $urandom_range(0, 255);
        wild = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < 6; i++)
        begin
            if (wild)
                s = $urandom_range(0, 255);
            else
                s = int'(base) + int'($urandom_range(0, 48)) - 24;
            if ($urandom_range(0, 15) == 0)
                s = $urandom_range(0, 1) * 255;
            v[i] = (s < 0) ? 8'd0 : ((s > 255) ? 8'd255 : s[7:0]);
        end
        return fixed_beat(c, r, v[0], v[1], v[2], v[3], v[4], v[5]);
    endfunction

    // one beat on the input; valid stays up after the beat unless the
    // burst is over, then a random gap follows
    task automatic send_pixel(input pixel_beat_t b);
        int unsigned gap;
        @(negedge clk);
        in_valid     <= 1'b1;
        column       <= b.column;
        row          <= b.row;
        mc_above     <= b.mc_above;
        mc_here      <= b.mc_here;
        mc_below     <= b.mc_below;
        mc_below_two <= b.mc_below_two;
        edge_here    <= b.edge_here;
        edge_below   <= b.edge_below;
        do
            @(posedge clk);
        while (!in_ready);
        predict_filtered_pixel(b);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 8);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
            // now and then a long stretch without gaps
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 30);
        end
    endtask

    // out-of-frame beat, placed past the width or past the height
    task automatic send_outside();
        int unsigned c;
        int unsigned r;
        if (cur_width < MAX_WIDTH && (cur_height > MAX_ROW || $urandom_range(0, 1)))
        begin
            c = $urandom_range(cur_width, MAX_WIDTH - 1);
            r = $urandom_range(0, MAX_ROW);
        end
        else if (cur_height <= MAX_ROW)
        begin
            c = $urandom_range(0, MAX_WIDTH - 1);
            r = $urandom_range(cur_height, MAX_ROW);
        end
        else
        begin
            return;
        end
        send_pixel(make_beat(c, r));
    endtask

    // quiet input, all predicted pixels out, pipe drained of dropped beats
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx, input int unsigned data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data[CFG_DAT_BITS-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_FRAME_WIDTH:  cur_width  = data[WIDTH_BITS-1:0];
            CFG_FRAME_HEIGHT: cur_height = data[HEIGHT_BITS-1:0];
            CFG_FIELD_PARITY: cur_parity = data[0];
            default:          ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_frame(input int unsigned w, input int unsigned h, input int unsigned p);
        wait_idle();
        cfg_write(CFG_FRAME_WIDTH, w);
        cfg_write(CFG_FRAME_HEIGHT, h);
        cfg_write(CFG_FIELD_PARITY, p);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset frame 720x576, kept field even
    task automatic test_reset_state();
        send_pixel(fixed_beat(0, 0, 0, 0, 0, 0, 0, 0));
        send_pixel(fixed_beat(1, 0, 255, 255, 255, 255, 255, 255));
        send_pixel(fixed_beat(2, 0, 10, 200, 30, 40, 50, 60));
        // interpolated row: mix equal to the larger neighbor, then to the smaller one
        send_pixel(fixed_beat(0, 1, 0, 255, 255, 0, 255, 255));
        send_pixel(fixed_beat(1, 1, 255, 0, 0, 255, 0, 0));
        // mix under both neighbors, upper one wins
        send_pixel(fixed_beat(2, 1, 100, 50, 120, 80, 90, 70));
        // last row interpolated, row above stands in for the missing one
        send_pixel(fixed_beat(0, 575, 40, 10, 200, 0, 250, 0));
        // row below is the last interpolated row, no row two below
        send_pixel(fixed_beat(1, 574, 20, 30, 40, 50, 60, 70));
        // just outside the height and the width
        send_pixel(fixed_beat(3, 576, 1, 2, 3, 4, 5, 6));
        send_pixel(fixed_beat(720, 0, 1, 2, 3, 4, 5, 6));
    endtask

    task automatic test_frame_extremes();
        set_frame(2048, 4096, 1);
        send_pixel(fixed_beat(2047, 0, 255, 255, 255, 255, 255, 255));
        send_pixel(fixed_beat(1024, 4095, 0, 128, 255, 0, 64, 192));
        send_pixel(fixed_beat(2047, 4094, 0, 255, 0, 255, 255, 0));
        send_pixel(fixed_beat(2047, 4095, 255, 0, 255, 0, 0, 255));
        // height past the row range: every row above zero blends
        set_frame(4095, 8191, 0);
        send_pixel(fixed_beat(2047, 4095, 200, 20, 220, 0, 0, 255));
        // small frame of two rows
        set_frame(8, 2, 0);
        send_pixel(fixed_beat(7, 0, 9, 99, 199, 250, 3, 33));
        send_pixel(fixed_beat(7, 1, 60, 250, 0, 255, 255, 0));
        send_pixel(fixed_beat(8, 0, 1, 1, 1, 1, 1, 1));
        send_pixel(fixed_beat(0, 2, 1, 1, 1, 1, 1, 1));
    endtask

    task automatic test_degenerate_frames();
        // zero height drops everything
        set_frame(8, 0, 1);
        send_pixel(fixed_beat(0, 0, 5, 6, 7, 8, 9, 10));
        // single row passes through
        set_frame(8, 1, 1);
        send_pixel(fixed_beat(0, 0, 5, 6, 7, 8, 9, 10));
        send_pixel(fixed_beat(0, 1, 5, 6, 7, 8, 9, 10));
        // write to the unused index must not disturb the frame
        wait_idle();
        cfg_write(CFG_SPARE, 13'h1FFF);
        send_pixel(fixed_beat(1, 0, 11, 22, 33, 44, 55, 66));
        // zero width drops everything
        set_frame(0, 2, 0);
        send_pixel(fixed_beat(0, 0, 5, 6, 7, 8, 9, 10));
    endtask

    // whole frames in raster order with out-of-frame noise mixed in;
    // some frames are cut short
    task automatic test_raster_frames();
        int unsigned n;
        int unsigned w;
        int unsigned h;
        bit          stop;
        n = 0;
        while (n < 480)
        begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 7) : $urandom_range(8, 32);
            h = $urandom_range(2, 12);
            set_frame(w, h, $urandom_range(0, 1));
            stop = 1'b0;
            for (int unsigned r = 0; r < h && !stop; r++)
            begin
                for (int unsigned c = 0; c < w; c++)
                begin
                    if ($urandom_range(0, 11) == 0)
                        send_outside();
                    send_pixel(make_beat(c, r));
                    n++;
                end
                stop = (r > 0 && $urandom_range(0, 19) == 0);
            end
        end
    endtask

    // scattered positions on small and large frames; a blended row is only
    // sent where its column already holds a previous row
    task automatic test_random_positions();
        int unsigned c;
        int unsigned r;
        int unsigned wlim;
        int unsigned hlim;
        for (int unsigned k = 0; k < 240; k++)
        begin
            if (k % 60 == 0)
            begin
                if ($urandom_range(0, 1))
                    set_frame($urandom_range(8, 2048), $urandom_range(2, 8191),
                              $urandom_range(0, 1));
                else
                    set_frame($urandom_range(8, 40), $urandom_range(2, 16),
                              $urandom_range(0, 1));
            end
            if ($urandom_range(0, 9) == 0)
                send_outside();
            wlim = (cur_width > MAX_WIDTH) ? MAX_WIDTH : cur_width;
            hlim = (cur_height > MAX_ROW + 1) ? MAX_ROW + 1 : cur_height;
            // favor the low columns that earlier frames have filled
            if (wlim > 64 && $urandom_range(0, 1))
                c = $urandom_range(0, 63);
            else
                c = $urandom_range(0, wlim - 1);
            r = $urandom_range(0, hlim - 1);
            if (r >= 1 && r + 1 < cur_height && !line_written[c])
                r = 0;
            send_pixel(make_beat(c, r));
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reset_state();
        test_frame_extremes();
        test_degenerate_frames();
        test_raster_frames();
        test_random_positions();
        wait_idle();
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
